// ===== hw/rtl/cprf_pkg.sv =====
// Shared types and constants of the centroid radius pixel filter.
// Used by centroid_radius_pixel_filter and cprf_ram; depends on nothing.
package cprf_pkg;

	localparam int PIXEL_W    = 8;
	localparam int CENT_W     = 17;
	localparam int SIZE_W     = 10;
	localparam int RADIUS_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int DEF_RAM_WIDTH  = 1;
	localparam int DEF_RAM_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = 10'd512;
	localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = 10'd512;
	localparam logic [RADIUS_W-1:0] RST_RADIUS_Q4    = 16'd0;

	localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 8'd255;
	localparam logic [PIXEL_W-1:0] BLACK_PIXEL = 8'd0;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_RADIUS_Q4    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               req_type;
		logic [PIXEL_W-1:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_out;
		logic [CENT_W-1:0]  centroid_col_q8;
		logic [CENT_W-1:0]  centroid_row_q8;
		logic               last_of_frame;
		logic               not_ready;
	} res_t;

endpackage

// ===== hw/rtl/cprf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on cprf_pkg for default sizes only.
module cprf_ram import cprf_pkg::*; #(
	parameter int WIDTH = DEF_RAM_WIDTH,
	parameter int DEPTH = DEF_RAM_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/centroid_radius_pixel_filter.sv =====
// Centroid radius pixel filter, top level. Uses cprf_pkg and cprf_ram.
// Loads give no result. A read gives its result through read pipeline stages 1, 2 and 3;
// loads and reads can be accepted every cycle while busy is low, and the receiver cannot stall.
// The last load of a frame with nonzero pixels starts a restoring divider that runs with busy
// high. Async reset clears positions, sums, centroid and frame_ready and restores register
// defaults; the white bitmap is not cleared.
module centroid_radius_pixel_filter import cprf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  res_valid,
	output res_t                  res
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PW     = (CW > RW) ? CW : RW;
	localparam int SUM_W  = PW + CNT_W;
	localparam int DIV_W  = SUM_W + 8;
	localparam int DCNT_W = $clog2(DIV_W);
	localparam int DW     = (PW + 8 > CENT_W) ? PW + 8 : CENT_W;
	localparam int SQ_W   = 2 * DW;
	localparam int R2_W   = 2 * RADIUS_W;
	localparam int CMP_W  = (SQ_W + 1 > R2_W + 8) ? SQ_W + 1 : R2_W + 8;

	function automatic logic [31:0] eff_size(input logic [SIZE_W-1:0] v, input int max_v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0) return 32'd1;
		else if (v32 > 32'(max_v)) return 32'(max_v);
		else return v32;
	endfunction

	// one restoring division step: returns {remainder, shifted numerator/quotient}
	function automatic logic [CNT_W+DIV_W-1:0] div_step(input logic [CNT_W-1:0] rem,
			input logic [DIV_W-1:0] num, input logic [CNT_W-1:0] d);
		logic [CNT_W:0]   trial;
		logic             ge;
		logic [CNT_W-1:0] rem_n;
		trial = {rem, num[DIV_W-1]};
		ge    = trial >= {1'b0, d};
		rem_n = ge ? CNT_W'(trial - {1'b0, d}) : CNT_W'(trial);
		return {rem_n, num[DIV_W-2:0], ge};
	endfunction

	function automatic logic [DW-1:0] abs_diff(input logic [PW-1:0] pos,
			input logic [CENT_W-1:0] cent);
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		a = DW'({pos, 8'd0});
		b = DW'(cent);
		return (a >= b) ? a - b : b - a;
	endfunction

	// configuration
	logic [SIZE_W-1:0]   frame_width_q, frame_height_q;
	logic [RADIUS_W-1:0] radius_q4_q;

	// state
	logic [CW-1:0]     load_col_q, read_col_q;
	logic [RW-1:0]     load_row_q, read_row_q;
	logic [SUM_W-1:0]  sum_col_q, sum_row_q;
	logic [CNT_W-1:0]  count_q;
	logic [CENT_W-1:0] cent_col_q, cent_row_q;
	logic              frame_ready_q;

	// divider
	logic              div_active_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [DIV_W-1:0]  num_col_q, num_row_q;
	logic [CNT_W-1:0]  rem_col_q, rem_row_q;
	logic [CNT_W+DIV_W-1:0] step_col, step_row;

	// read pipeline
	logic              valid_s1, nr_s1, last_s1;
	logic [DW-1:0]     dx_s1, dy_s1;
	logic [CENT_W-1:0] ccol_s1, crow_s1;
	logic              valid_s2, nr_s2, last_s2, bit_s2;
	logic [SQ_W-1:0]   dx2_s2, dy2_s2;
	logic [R2_W-1:0]   r2_s2;
	logic [CENT_W-1:0] ccol_s2, crow_s2;
	logic              res_valid_q;
	res_t              res_q;

	logic [31:0]       w_eff, h_eff;
	logic              acc, load_acc, read_acc;
	logic              ld_first, ld_nz, ld_last_col, ld_last_row;
	logic              rd_last_col, rd_last_row;
	logic [SUM_W-1:0]  sum_col_nx, sum_row_nx;
	logic [CNT_W-1:0]  count_nx;
	logic [AW-1:0]     waddr, raddr;
	logic              wbit, rbit;
	logic              keep;
	logic [CMP_W-1:0]  d2_sum;

	assign busy     = div_active_q;
	assign acc      = start && !busy;
	assign load_acc = acc && (req.req_type == REQ_LOAD);
	assign read_acc = acc && (req.req_type == REQ_READ);

	assign w_eff = eff_size(frame_width_q, MAX_WIDTH);
	assign h_eff = eff_size(frame_height_q, MAX_HEIGHT);

	always_comb begin
		ld_first    = (load_col_q == '0) && (load_row_q == '0);
		ld_nz       = req.pixel_in != BLACK_PIXEL;
		ld_last_col = (32'(load_col_q) + 32'd1) >= w_eff;
		ld_last_row = (32'(load_row_q) + 32'd1) >= h_eff;
		rd_last_col = (32'(read_col_q) + 32'd1) >= w_eff;
		rd_last_row = (32'(read_row_q) + 32'd1) >= h_eff;
		sum_col_nx  = (ld_first ? '0 : sum_col_q) + (ld_nz ? SUM_W'(load_col_q) : '0);
		sum_row_nx  = (ld_first ? '0 : sum_row_q) + (ld_nz ? SUM_W'(load_row_q) : '0);
		count_nx    = (ld_first ? '0 : count_q) + (ld_nz ? CNT_W'(1) : '0);
		waddr       = AW'(load_row_q) * AW'(MAX_WIDTH) + AW'(load_col_q);
		raddr       = AW'(read_row_q) * AW'(MAX_WIDTH) + AW'(read_col_q);
		wbit        = req.pixel_in == WHITE_PIXEL;
		step_col    = div_step(rem_col_q, num_col_q, count_q);
		step_row    = div_step(rem_row_q, num_row_q, count_q);
	end

	cprf_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk     (clk),
		.we      (load_acc),
		.waddr   (waddr),
		.wdata   (wbit),
		.re      (read_acc && frame_ready_q),
		.raddr   (raddr),
		.rd_data (rbit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			radius_q4_q    <= RST_RADIUS_Q4;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[SIZE_W-1:0];
				REG_RADIUS_Q4:    radius_q4_q    <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// load side, read position and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q    <= '0;
			load_row_q    <= '0;
			read_col_q    <= '0;
			read_row_q    <= '0;
			sum_col_q     <= '0;
			sum_row_q     <= '0;
			count_q       <= '0;
			cent_col_q    <= '0;
			cent_row_q    <= '0;
			frame_ready_q <= 1'b0;
			div_active_q  <= 1'b0;
			div_cnt_q     <= '0;
		end else begin
			if (load_acc) begin
				sum_col_q <= sum_col_nx;
				sum_row_q <= sum_row_nx;
				count_q   <= count_nx;
				if (ld_first && !(ld_last_col && ld_last_row)) begin
					frame_ready_q <= 1'b0;
				end
				if (ld_last_col && ld_last_row) begin
					load_col_q <= '0;
					load_row_q <= '0;
					read_col_q <= '0;
					read_row_q <= '0;
					if (count_nx == '0) begin
						cent_col_q    <= '0;
						cent_row_q    <= '0;
						frame_ready_q <= 1'b1;
					end else begin
						// frame_ready stays low until the quotient is in
						frame_ready_q <= 1'b0;
						div_active_q  <= 1'b1;
						div_cnt_q     <= '0;
					end
				end else if (ld_last_col) begin
					load_col_q <= '0;
					load_row_q <= load_row_q + RW'(1);
				end else begin
					load_col_q <= load_col_q + CW'(1);
				end
			end

			if (read_acc && frame_ready_q) begin
				if (rd_last_col && rd_last_row) begin
					read_col_q <= '0;
					read_row_q <= '0;
				end else if (rd_last_col) begin
					read_col_q <= '0;
					read_row_q <= read_row_q + RW'(1);
				end else begin
					read_col_q <= read_col_q + CW'(1);
				end
			end

			if (div_active_q) begin
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
				if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
					div_active_q  <= 1'b0;
					frame_ready_q <= 1'b1;
					cent_col_q    <= step_col[CENT_W-1:0];
					cent_row_q    <= step_row[CENT_W-1:0];
				end
			end
		end
	end

	// divider datapath: no reset needed
	always_ff @(posedge clk) begin
		if (load_acc && ld_last_col && ld_last_row) begin
			num_col_q <= {sum_col_nx, 8'd0};
			num_row_q <= {sum_row_nx, 8'd0};
			rem_col_q <= '0;
			rem_row_q <= '0;
		end else if (div_active_q) begin
			{rem_col_q, num_col_q} <= step_col;
			{rem_row_q, num_row_q} <= step_row;
		end
	end

	// read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= read_acc;
			valid_s2    <= valid_s1;
			res_valid_q <= valid_s2;
		end
	end

	assign d2_sum = CMP_W'(dx2_s2) + CMP_W'(dy2_s2);
	assign keep   = bit_s2 && (d2_sum <= CMP_W'({r2_s2, 8'd0}));

	// read pipeline payload
	always_ff @(posedge clk) begin
		// stage 1: distances to the centroid, bitmap read in flight
		nr_s1   <= !frame_ready_q;
		last_s1 <= rd_last_col && rd_last_row;
		dx_s1   <= abs_diff(PW'(read_col_q), cent_col_q);
		dy_s1   <= abs_diff(PW'(read_row_q), cent_row_q);
		ccol_s1 <= cent_col_q;
		crow_s1 <= cent_row_q;
		// stage 2: squares
		nr_s2   <= nr_s1;
		last_s2 <= last_s1;
		bit_s2  <= rbit;
		dx2_s2  <= dx_s1 * dx_s1;
		dy2_s2  <= dy_s1 * dy_s1;
		r2_s2   <= radius_q4_q * radius_q4_q;
		ccol_s2 <= ccol_s1;
		crow_s2 <= crow_s1;
		// stage 3: compare and present the transaction
		res_q.pixel_out       <= (!nr_s2 && keep) ? WHITE_PIXEL : BLACK_PIXEL;
		res_q.centroid_col_q8 <= nr_s2 ? '0 : ccol_s2;
		res_q.centroid_row_q8 <= nr_s2 ? '0 : crow_s2;
		res_q.last_of_frame   <= !nr_s2 && last_s2;
		res_q.not_ready       <= nr_s2;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_res_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(start && !busy && (req.req_type == REQ_READ), 3))
		else $error("result without a read transaction three cycles earlier");

	a_div_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_active_q |-> !frame_ready_q)
		else $error("frame marked ready while the centroid division runs");

	a_not_ready_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.not_ready) |-> (res.pixel_out == BLACK_PIXEL && !res.last_of_frame
			&& res.centroid_col_q8 == '0 && res.centroid_row_q8 == '0))
		else $error("not-ready transaction carries data");

	a_div_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(div_active_q) |-> frame_ready_q)
		else $error("division ended without setting frame ready");

endmodule
